### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the note window shift block. They expect clk and
// arst_n in scope and compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/nwrs_pkg.sv
// ----------------------------------------------------------------------------
// nwrs_pkg
// Shared types and constants of the note window shift block.
// ----------------------------------------------------------------------------
`default_nettype none

package nwrs_pkg;

	// default ring depth
	localparam int CAPACITY_DEF = 16;

	// field widths
	localparam int NOTE_IN_W  = 8;
	localparam int NOTE_W     = 7;
	localparam int WIN_W      = 5;
	localparam int SHIFT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register reset values
	localparam logic [WIN_W-1:0]  WINDOW_RESET = 5'd16;
	localparam logic [NOTE_W-1:0] PIVOT_RESET  = 7'd60;
	localparam logic [NOTE_W-1:0] SPREAD_RESET = 7'd12;

	// highest note that is stored
	localparam logic [NOTE_IN_W-1:0] NOTE_MAX = 8'd127;

	// shift sizes in semitones
	localparam logic signed [SHIFT_W-1:0] SHIFT_NEAR = 6'sd12;
	localparam logic signed [SHIFT_W-1:0] SHIFT_FAR  = 6'sd24;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SIZE  = 2'd0,
		CFG_PIVOT_NOTE   = 2'd1,
		CFG_SPREAD_LIMIT = 2'd2
	} cfg_reg_t;

	// configuration bundle
	typedef struct packed {
		logic [WIN_W-1:0]  window_size;
		logic [NOTE_W-1:0] pivot_note;
		logic [NOTE_W-1:0] spread_limit;
	} cfg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUMS,
		ST_CAND,
		ST_SCAN,
		ST_MUL1,
		ST_MUL2,
		ST_FINISH
	} state_t;

	// tag of the read data returning from the note memory
	typedef enum logic [1:0] {
		RD_NONE,
		RD_SUM,
		RD_CAND,
		RD_CMP
	} rd_kind_t;

endpackage

`default_nettype wire

### hw/rtl/nwrs_store.sv
// ----------------------------------------------------------------------------
// nwrs_store
// Note ring memory: one write port, one read port with registered data.
// Per-entry valid bits make never-written entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nwrs_store #(
	parameter int CAPACITY = nwrs_pkg::CAPACITY_DEF,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [IDX_W-1:0]            wr_addr,
	input  wire logic [nwrs_pkg::NOTE_W-1:0] wr_data,
	input  wire logic [IDX_W-1:0]            rd_addr,
	output logic      [nwrs_pkg::NOTE_W-1:0] rd_data
);

	logic [nwrs_pkg::NOTE_W-1:0] mem [CAPACITY];
	logic [CAPACITY-1:0]         vld_q;
	logic [nwrs_pkg::NOTE_W-1:0] raw_s1;
	logic                        vld_s1;

	// storage array and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_s1 <= mem[rd_addr];
		vld_s1 <= vld_q[rd_addr];
	end

	// written-entry marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = vld_s1 ? raw_s1 : '0;

endmodule

`default_nettype wire

### hw/rtl/nwrs_ctrl.sv
// ----------------------------------------------------------------------------
// nwrs_ctrl
// Sequencer and datapath: ring update, sum pass, pairwise rank scan for the
// two middle values, spread products, decision and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nwrs_ctrl #(
	parameter int CAPACITY = nwrs_pkg::CAPACITY_DEF,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire nwrs_pkg::cfg_t                      cfg,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [nwrs_pkg::NOTE_IN_W-1:0]      note_number,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     accepted,
	output logic signed [nwrs_pkg::SHIFT_W-1:0]      transposition,
	output logic                                     changed,
	output logic                                     wr_en,
	output logic [IDX_W-1:0]                         wr_addr,
	output logic [nwrs_pkg::NOTE_W-1:0]              wr_data,
	output logic [IDX_W-1:0]                         rd_addr,
	input  wire logic [nwrs_pkg::NOTE_W-1:0]         rd_data
);

	localparam int N_W   = $clog2(CAPACITY + 1);
	localparam int EW    = (N_W > nwrs_pkg::WIN_W) ? N_W : nwrs_pkg::WIN_W;
	localparam int SUM_W = nwrs_pkg::NOTE_W + N_W;
	localparam int SQ_W  = 2 * nwrs_pkg::NOTE_W + N_W;
	localparam int SQR_W = 2 * nwrs_pkg::NOTE_W;
	localparam int P3_W  = nwrs_pkg::NOTE_W + N_W;
	localparam int PW    = 2 * P3_W;
	localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

	nwrs_pkg::state_t   state_q, state_d;
	nwrs_pkg::rd_kind_t rd_kind_d, rkind_s1;
	logic               rlast_s1;

	logic [IDX_W-1:0] j_q, i_q, ptr_q;
	logic [N_W-1:0]   n_q, klo_q, khi_q, fill_q;
	logic signed [nwrs_pkg::SHIFT_W-1:0] shift_q;
	logic             acc_q;

	logic [SUM_W-1:0]            sum_q;
	logic [SQ_W-1:0]             sq_q;
	logic [nwrs_pkg::NOTE_W-1:0] cand_q, med_lo_q, med_hi_q;
	logic [N_W-1:0]              lt_q, le_q;
	logic [PW-1:0]               p1_q, p2_q, p4_q, spread_q;
	logic [P3_W-1:0]             p3_q;

	// effective window, pointer and fill for the incoming note
	logic [EW-1:0]  ws_e;
	logic [N_W-1:0] win, wp_n, wp_inc, fc, fill_new;
	logic [IDX_W-1:0] wp, ptr_new;
	logic           note_ok, in_fire, out_free, j_last, i_last;

	always_comb begin
		ws_e     = EW'(cfg.window_size);
		win      = (ws_e > CAP_E) ? N_W'(CAP_E) : N_W'(ws_e);
		wp_n     = (N_W'(ptr_q) >= win) ? '0 : N_W'(ptr_q);
		wp       = IDX_W'(wp_n);
		wp_inc   = wp_n + N_W'(1);
		ptr_new  = (wp_inc == win) ? '0 : IDX_W'(wp_inc);
		fc       = (fill_q > win) ? win : fill_q;
		fill_new = (fc < win) ? fc + N_W'(1) : fc;
		note_ok  = (note_number <= nwrs_pkg::NOTE_MAX) && (win != '0);
		in_fire  = in_valid && !in_stall;
		out_free = !out_valid || !out_stall;
		j_last   = (N_W'(j_q) == n_q - N_W'(1));
		i_last   = (N_W'(i_q) == n_q - N_W'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nwrs_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = note_ok ? nwrs_pkg::ST_SUMS : nwrs_pkg::ST_FINISH;
				end
			end
			nwrs_pkg::ST_SUMS: begin
				if (j_last) begin
					state_d = nwrs_pkg::ST_CAND;
				end
			end
			nwrs_pkg::ST_CAND: state_d = nwrs_pkg::ST_SCAN;
			nwrs_pkg::ST_SCAN: begin
				if (j_last) begin
					state_d = i_last ? nwrs_pkg::ST_MUL1 : nwrs_pkg::ST_CAND;
				end
			end
			nwrs_pkg::ST_MUL1: state_d = nwrs_pkg::ST_MUL2;
			nwrs_pkg::ST_MUL2: state_d = nwrs_pkg::ST_FINISH;
			nwrs_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = nwrs_pkg::ST_IDLE;
				end
			end
			default: state_d = nwrs_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshake, memory ports, read tag
	always_comb begin
		in_stall  = (state_q != nwrs_pkg::ST_IDLE);
		wr_en     = in_fire && note_ok;
		wr_addr   = wp;
		wr_data   = note_number[nwrs_pkg::NOTE_W-1:0];
		rd_addr   = (state_q == nwrs_pkg::ST_CAND) ? i_q : j_q;
		unique case (state_q)
			nwrs_pkg::ST_SUMS: rd_kind_d = nwrs_pkg::RD_SUM;
			nwrs_pkg::ST_CAND: rd_kind_d = nwrs_pkg::RD_CAND;
			nwrs_pkg::ST_SCAN: rd_kind_d = nwrs_pkg::RD_CMP;
			default:           rd_kind_d = nwrs_pkg::RD_NONE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nwrs_pkg::ST_IDLE;
			rkind_s1 <= nwrs_pkg::RD_NONE;
			ptr_q    <= '0;
			fill_q   <= '0;
		end else begin
			state_q  <= state_d;
			rkind_s1 <= rd_kind_d;
			if (wr_en) begin
				ptr_q  <= ptr_new;
				fill_q <= fill_new;
			end
		end
	end

	// scan counters and window size of this item
	always_ff @(posedge clk) begin
		rlast_s1 <= j_last;
		if (in_fire) begin
			acc_q <= note_ok;
			n_q   <= fill_new;
			klo_q <= (fill_new - N_W'(1)) >> 1;
			khi_q <= fill_new >> 1;
			j_q   <= '0;
			i_q   <= '0;
		end else if (state_q == nwrs_pkg::ST_SUMS || state_q == nwrs_pkg::ST_SCAN) begin
			j_q <= j_last ? '0 : j_q + IDX_W'(1);
			if (state_q == nwrs_pkg::ST_SCAN && j_last) begin
				i_q <= i_q + IDX_W'(1);
			end
		end
	end

	// sum pass
	logic [SQR_W-1:0] sqr;
	assign sqr = SQR_W'(rd_data) * SQR_W'(rd_data);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (rkind_s1 == nwrs_pkg::RD_SUM) begin
			sum_q <= sum_q + SUM_W'(rd_data);
			sq_q  <= sq_q + SQ_W'(sqr);
		end
	end

	// rank scan: candidate value against every window entry
	logic [N_W-1:0] lt_f, le_f;
	assign lt_f = lt_q + N_W'(rd_data < cand_q);
	assign le_f = le_q + N_W'(rd_data <= cand_q);

	always_ff @(posedge clk) begin
		if (rkind_s1 == nwrs_pkg::RD_CAND) begin
			cand_q <= rd_data;
		end
		if (in_fire) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (rkind_s1 == nwrs_pkg::RD_CMP) begin
			if (rlast_s1) begin
				lt_q <= '0;
				le_q <= '0;
				// candidate covers the sorted slots lt_f .. le_f-1
				if (lt_f <= klo_q && klo_q < le_f) begin
					med_lo_q <= cand_q;
				end
				if (lt_f <= khi_q && khi_q < le_f) begin
					med_hi_q <= cand_q;
				end
			end else begin
				lt_q <= lt_f;
				le_q <= le_f;
			end
		end
	end

	// spread products, one multiply per product register, and their difference
	always_ff @(posedge clk) begin
		if (state_q == nwrs_pkg::ST_MUL1) begin
			p1_q <= PW'(n_q) * PW'(sq_q);
			p2_q <= PW'(sum_q) * PW'(sum_q);
			p3_q <= P3_W'(cfg.spread_limit) * P3_W'(n_q);
		end
		if (state_q == nwrs_pkg::ST_MUL2) begin
			p4_q     <= PW'(p3_q) * PW'(p3_q);
			spread_q <= p1_q - p2_q;
		end
	end

	// decision
	logic        down, wide;
	logic [nwrs_pkg::NOTE_W:0] pair;
	logic signed [nwrs_pkg::SHIFT_W-1:0] mag, res_shift;

	always_comb begin
		pair      = {1'b0, med_lo_q} + {1'b0, med_hi_q};
		down      = pair >= {cfg.pivot_note, 1'b0};
		wide      = spread_q >= p4_q;
		mag       = wide ? nwrs_pkg::SHIFT_FAR : nwrs_pkg::SHIFT_NEAR;
		res_shift = acc_q ? (down ? -mag : mag) : shift_q;
	end

	// result register and shift commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			shift_q   <= '0;
		end else if (state_q == nwrs_pkg::ST_FINISH && out_free) begin
			out_valid <= 1'b1;
			shift_q   <= res_shift;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nwrs_pkg::ST_FINISH && out_free) begin
			accepted      <= acc_q;
			transposition <= res_shift;
			changed       <= acc_q && (res_shift != shift_q);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/note_window_register_shift.sv
// Sequence: a stored note runs the sum pass, then a candidate read and a
// window scan per entry, the two product states and FINISH; a rejected
// note goes from IDLE straight to FINISH. Flow: one note at a time; the
// next is taken the cycle after the result is loaded, paced by the single
// read port of the note memory, used once per pair in the scan. Reset:
// asynchronous; control, pointer, valid-bit and config registers clear at once.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// note_window_register_shift
// Keeps the recent notes in a ring memory and derives a transposition from
// their median and spread. Holds the configuration registers.
// ----------------------------------------------------------------------------
module note_window_register_shift #(
	parameter int CAPACITY = nwrs_pkg::CAPACITY_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [nwrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [nwrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [nwrs_pkg::NOTE_IN_W-1:0]   note_number,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  accepted,
	output logic signed [nwrs_pkg::SHIFT_W-1:0]   transposition,
	output logic                                  changed
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	nwrs_pkg::cfg_t cfg_q;

	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr, rd_addr;
	logic [nwrs_pkg::NOTE_W-1:0] wr_data, rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size  <= nwrs_pkg::WINDOW_RESET;
			cfg_q.pivot_note   <= nwrs_pkg::PIVOT_RESET;
			cfg_q.spread_limit <= nwrs_pkg::SPREAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nwrs_pkg::CFG_WINDOW_SIZE:
					cfg_q.window_size <= cfg_data[nwrs_pkg::WIN_W-1:0];
				nwrs_pkg::CFG_PIVOT_NOTE:   cfg_q.pivot_note   <= cfg_data;
				nwrs_pkg::CFG_SPREAD_LIMIT: cfg_q.spread_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	nwrs_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	nwrs_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.note_number  (note_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.transposition(transposition),
		.changed      (changed),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	// checks
	`ASSERT_IMPL(a_write_on_accept, wr_en, in_valid && !in_stall)
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ASSERT_IMPL(a_reject_no_change, out_valid && !accepted, !changed)
	`ASSERT_IMPL(a_shift_set, out_valid && accepted, transposition != '0)

endmodule

`default_nettype wire
